// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define KF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define KF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define KF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KF_ASSERT(lbl, prop, msg)
`define KF_ASSERT_IMPL(lbl, ante, cons, msg)
`define KF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/kf3_pkg.sv
// Types, constants and helper functions of the three-axis Kalman filter.
package kf3_pkg;

    localparam logic signed [31:0] COV_ONE = 32'sd16777216;
    localparam logic signed [63:0] COV_HALF = 64'sd8388608;

    localparam logic REG_SENSOR_MODE = 1'b0;
    localparam logic REG_PROCESS_NOISE = 1'b1;

    typedef logic [5:0] rf_addr_t;

    localparam rf_addr_t A_P = 6'd0;
    localparam rf_addr_t A_PP = 6'd9;
    localparam rf_addr_t A_SM = 6'd18;
    localparam rf_addr_t A_COF = 6'd27;
    localparam rf_addr_t A_K = 6'd36;
    localparam rf_addr_t A_INNOV = 6'd45;
    localparam rf_addr_t A_PREV = 6'd48;
    localparam rf_addr_t A_IK = 6'd54;
    localparam rf_addr_t A_DET = 6'd63;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
        logic signed [31:0] est_z;
    } out_item_t;

    typedef enum logic [1:0] {OPK_ADD, OPK_MUL, OPK_DIV} op_kind_t;
    typedef enum logic [1:0] {AS_MEM, AS_SAMPLE, AS_ONE, AS_ZERO} a_src_t;
    typedef enum logic [2:0] {BS_MEM, BS_ZERO, BS_NOISE, BS_QCONST, BS_ACC} b_src_t;

    typedef struct packed {
        op_kind_t   kind;
        a_src_t     a_src;
        b_src_t     b_src;
        logic       neg;
        logic       clr;
        logic       wr;
        logic       out_en;
        logic [1:0] lane;
        rf_addr_t   a_addr;
        rf_addr_t   b_addr;
        rf_addr_t   dst;
    } uop_t;

    typedef struct packed {
        logic load_in;
        logic restart;
        logic ex;
        logic ac;
        logic dv;
        logic div_start;
        logic push;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_busy;
        logic out_free;
    } dp_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
        return {2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c};
    endfunction

    function automatic logic is_diag(input logic [3:0] i);
        return (i == 4'd0) || (i == 4'd4) || (i == 4'd8);
    endfunction

    function automatic logic signed [31:0] q_const(input logic [3:0] i, input logic gyro);
        logic signed [31:0] v;
        if (gyro)
        begin
            v = is_diag(i) ? COV_ONE : 32'sd0;
        end
        else
        begin
            case (i)
                4'd0:    v = 32'sd11147;
                4'd1:    v = 32'sd1181;
                4'd2:    v = 32'sd1171;
                4'd3:    v = 32'sd1181;
                4'd4:    v = 32'sd16403;
                4'd5:    v = 32'sd4594;
                4'd6:    v = 32'sd1171;
                4'd7:    v = 32'sd4594;
                4'd8:    v = 32'sd15432;
                default: v = 32'sd0;
            endcase
        end
        return v;
    endfunction

    function automatic logic signed [31:0] rf_default(input rf_addr_t a);
        return ((a == 6'd0) || (a == 6'd4) || (a == 6'd8)) ? COV_ONE : 32'sd0;
    endfunction

endpackage

// File: design/kalman_filter_3axis.sv
// Top level of the three-axis Kalman filter.
// A request with cmd set restarts the filter and gives no result. The first sample after
// reset or restart is returned unchanged. Every later sample runs the full update,
// one operation at a time through a single 32 by 32 multiplier and a two-port
// register file; each of the nine gain entries waits on the one-bit-per-cycle
// divider, which dominates the update time. A new request is taken while the
// previous result waits in the output register.
module kalman_filter_3axis (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [30:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  kf3_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output kf3_pkg::out_item_t  out_data
);
    import kf3_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    kf3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_cmd   (in_data.cmd),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    kf3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`include "assert_macros.svh"

    `KF_ASSERT_IMPL(a_div_idle_at_start, cmd.div_start, !sts.div_busy, "divider restarted while busy")
    `KF_ASSERT_NEXT(a_push_shows_result, cmd.push, out_valid, "pushed result not presented")
    `KF_ASSERT_NEXT(a_restart_no_result, in_valid && in_ready && in_data.cmd, !$rose(out_valid), "restart produced a result")
    `KF_ASSERT(a_one_phase, $onehot0({cmd.ex, cmd.ac, cmd.dv}), "datapath given overlapping steps")

endmodule

// File: design/kf3_div.sv
// Serial signed divider giving sat32((num * 2^24) / den), truncated toward zero.
module kf3_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] quot
);
    import kf3_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [55:0] q_reg;
    logic [31:0] dmag_reg;
    logic        neg_reg;
    logic signed [31:0] quot_reg;

    logic [32:0] num_mag;
    logic [32:0] den_mag;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_sub;
    logic signed [31:0] result;

    assign num_mag = num[31] ? (33'd0 - {num[31], num}) : {1'b0, num};
    assign den_mag = den[31] ? (33'd0 - {den[31], den}) : {1'b0, den};
    assign rem_sh = {rem_reg, q_reg[55]};
    assign ge = rem_sh >= {1'b0, dmag_reg};
    assign rem_sub = rem_sh - {1'b0, dmag_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg > 56'd2147483648)
            begin
                result = 32'sh80000000;
            end
            else
            begin
                result = 32'sd0 - q_reg[31:0];
            end
        end
        else if (q_reg > 56'd2147483647)
        begin
            result = 32'sh7FFFFFFF;
        end
        else
        begin
            result = q_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= (den == 32'sd0) ? 6'd0 : 6'd56;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != 6'd0)
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 32'd0;
            q_reg <= (den == 32'sd0) ? 56'd0 : {num_mag[31:0], 24'd0};
            dmag_reg <= den_mag[31:0];
            neg_reg <= num[31] ^ den[31];
        end
        else if (busy_reg && (cnt_reg != 6'd0))
        begin
            rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
            q_reg <= {q_reg[54:0], ge};
        end
        if (busy_reg && (cnt_reg == 6'd0))
        begin
            quot_reg <= result;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: design/kf3_dp.sv
// Datapath: register file, multiply-accumulate unit, divider and result register.
module kf3_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [30:0]         cfg_data,
    input  kf3_pkg::in_item_t   in_data,
    input  logic                out_ready,
    output logic                out_valid,
    output kf3_pkg::out_item_t  out_data,
    input  kf3_pkg::dp_cmd_t    cmd,
    output kf3_pkg::dp_sts_t    sts
);
    import kf3_pkg::*;

    logic        mode_reg;
    logic [30:0] noise_reg;
    logic signed [31:0] samp_reg [0:2];
    logic signed [31:0] res_reg [0:2];
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic [31:0] rf_mem [0:63];
    logic [63:0] valid_reg;
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic        va_reg;
    logic        vb_reg;
    rf_addr_t    aq_reg;
    rf_addr_t    bq_reg;

    logic signed [63:0] prod_reg;
    logic signed [47:0] acc_reg;

    logic signed [31:0] mem_a;
    logic signed [31:0] mem_b;
    logic signed [31:0] opa;
    logic signed [47:0] opb;
    logic signed [49:0] a50;
    logic signed [49:0] b50;
    logic signed [49:0] sum50;
    logic signed [31:0] add_res;
    logic signed [63:0] rnd;
    logic signed [39:0] term;
    logic signed [47:0] term48;
    logic signed [47:0] acc_base;
    logic signed [47:0] acc_next;
    logic signed [31:0] acc_sat;
    logic signed [31:0] m_sat;
    logic               we;
    logic signed [31:0] wdata;
    logic               div_busy;
    logic               div_done;
    logic signed [31:0] div_quot;

    assign mem_a = va_reg ? rd_a_reg : rf_default(aq_reg);
    assign mem_b = vb_reg ? rd_b_reg : rf_default(bq_reg);

    always_comb
    begin
        case (cmd.uop.a_src)
            AS_MEM:    opa = mem_a;
            AS_SAMPLE: opa = samp_reg[cmd.uop.a_addr[1:0]];
            AS_ONE:    opa = COV_ONE;
            default:   opa = 32'sd0;
        endcase
        case (cmd.uop.b_src)
            BS_MEM:    opb = {{16{mem_b[31]}}, mem_b};
            BS_NOISE:  opb = {17'd0, noise_reg};
            BS_QCONST: opb = 48'(q_const(cmd.uop.b_addr[3:0], mode_reg));
            BS_ACC:    opb = acc_reg;
            default:   opb = 48'sd0;
        endcase
    end

    assign a50 = {{18{opa[31]}}, opa};
    assign b50 = {{2{opb[47]}}, opb};
    assign sum50 = cmd.uop.neg ? (a50 - b50) : (a50 + b50);
    assign add_res = sat32(sum50);

    assign rnd = prod_reg + COV_HALF;
    assign term = rnd[63:24];
    assign term48 = {{8{term[39]}}, term};
    assign acc_base = cmd.uop.clr ? 48'sd0 : acc_reg;
    assign acc_next = cmd.uop.neg ? (acc_base - term48) : (acc_base + term48);
    assign acc_sat = sat32({{2{acc_next[47]}}, acc_next});
    assign m_sat = sat32({{2{acc_reg[47]}}, acc_reg});

    always_comb
    begin
        we = 1'b0;
        wdata = add_res;
        case (cmd.uop.kind)
            OPK_ADD:
            begin
                we = cmd.ex;
                wdata = add_res;
            end
            OPK_MUL:
            begin
                we = cmd.ac && cmd.uop.wr;
                wdata = acc_sat;
            end
            OPK_DIV:
            begin
                we = cmd.dv && div_done;
                wdata = div_quot;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    kf3_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (m_sat),
        .den   (mem_b),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[cmd.uop.dst] <= wdata;
        end
        rd_a_reg <= rf_mem[cmd.uop.a_addr];
        rd_b_reg <= rf_mem[cmd.uop.b_addr];
        va_reg <= valid_reg[cmd.uop.a_addr];
        vb_reg <= valid_reg[cmd.uop.b_addr];
        aq_reg <= cmd.uop.a_addr;
        bq_reg <= cmd.uop.b_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            samp_reg[0] <= in_data.sample_x;
            samp_reg[1] <= in_data.sample_y;
            samp_reg[2] <= in_data.sample_z;
        end
        if (cmd.ex && (cmd.uop.kind == OPK_MUL))
        begin
            prod_reg <= opa * mem_b;
        end
        if (cmd.ac)
        begin
            acc_reg <= acc_next;
        end
        if (we && cmd.uop.out_en)
        begin
            res_reg[cmd.uop.lane] <= wdata;
        end
        if (cmd.push)
        begin
            out_reg.est_x <= res_reg[0];
            out_reg.est_y <= res_reg[1];
            out_reg.est_z <= res_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mode_reg <= 1'b0;
            noise_reg <= 31'd16777216;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.restart)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[cmd.uop.dst] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SENSOR_MODE:   mode_reg <= cfg_data[0];
                    REG_PROCESS_NOISE: noise_reg <= cfg_data;
                    default:           mode_reg <= mode_reg;
                endcase
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign sts.div_done = div_done;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || out_ready;

endmodule

// File: design/kf3_ctrl.sv
// Controller: sequences the filter update one operation at a time.
module kf3_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    output kf3_pkg::dp_cmd_t  cmd,
    input  kf3_pkg::dp_sts_t  sts
);
    import kf3_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_RD, ST_EX, ST_AC, ST_DV, ST_PUSH} state_t;
    typedef enum logic [3:0] {
        PH_FIRST, PH_PP, PH_SM, PH_COF, PH_DET, PH_M, PH_INNOV, PH_EST, PH_IK, PH_P
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] r_reg, r_next;
    logic [1:0] c_reg, c_next;
    logic [1:0] t_reg, t_next;
    logic       primed_reg, primed_next;

    uop_t       uop;
    logic [3:0] idx;
    logic [1:0] r1, r2, c1, c2;
    logic [1:0] end_t;
    logic       row_only;
    logic       uop_end;
    logic       accept;
    phase_t     phase_after;

    assign idx = idx3(r_reg, c_reg);
    assign r1 = inc3(r_reg);
    assign r2 = inc3(r1);
    assign c1 = inc3(c_reg);
    assign c2 = inc3(c1);
    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        uop = '{kind: OPK_ADD, a_src: AS_ZERO, b_src: BS_ZERO, neg: 1'b0, clr: 1'b0,
                wr: 1'b0, out_en: 1'b0, lane: 2'd0, a_addr: A_P, b_addr: A_P, dst: A_P};
        case (phase_reg)
            PH_FIRST:
            begin
                uop.a_src = AS_SAMPLE;
                uop.a_addr = {4'd0, r_reg};
                uop.dst = A_PREV + {4'd0, r_reg};
                uop.out_en = 1'b1;
                uop.lane = r_reg;
            end
            PH_PP:
            begin
                uop.a_src = AS_MEM;
                uop.a_addr = A_P + {2'd0, idx};
                uop.b_src = is_diag(idx) ? BS_NOISE : BS_ZERO;
                uop.dst = A_PP + {2'd0, idx};
            end
            PH_SM:
            begin
                uop.a_src = AS_MEM;
                uop.a_addr = A_PP + {2'd0, idx};
                uop.b_src = BS_QCONST;
                uop.b_addr = {2'd0, idx};
                uop.dst = A_SM + {2'd0, idx};
            end
            PH_COF:
            begin
                uop.kind = OPK_MUL;
                uop.a_src = AS_MEM;
                uop.b_src = BS_MEM;
                uop.dst = A_COF + {2'd0, idx};
                if (t_reg == 2'd0)
                begin
                    uop.clr = 1'b1;
                    uop.a_addr = A_SM + {2'd0, idx3(r1, c1)};
                    uop.b_addr = A_SM + {2'd0, idx3(r2, c2)};
                end
                else
                begin
                    uop.neg = 1'b1;
                    uop.wr = 1'b1;
                    uop.a_addr = A_SM + {2'd0, idx3(r1, c2)};
                    uop.b_addr = A_SM + {2'd0, idx3(r2, c1)};
                end
            end
            PH_DET:
            begin
                uop.kind = OPK_MUL;
                uop.a_src = AS_MEM;
                uop.b_src = BS_MEM;
                uop.a_addr = A_SM + {4'd0, t_reg};
                uop.b_addr = A_COF + {4'd0, t_reg};
                uop.clr = (t_reg == 2'd0);
                uop.wr = (t_reg == 2'd2);
                uop.dst = A_DET;
            end
            PH_M:
            begin
                uop.a_src = AS_MEM;
                uop.b_src = BS_MEM;
                uop.dst = A_K + {2'd0, idx};
                if (t_reg == 2'd3)
                begin
                    uop.kind = OPK_DIV;
                    uop.b_addr = A_DET;
                end
                else
                begin
                    uop.kind = OPK_MUL;
                    uop.a_addr = A_PP + {2'd0, idx3(r_reg, t_reg)};
                    uop.b_addr = A_COF + {2'd0, idx3(c_reg, t_reg)};
                    uop.clr = (t_reg == 2'd0);
                end
            end
            PH_INNOV:
            begin
                uop.a_src = AS_SAMPLE;
                uop.a_addr = {4'd0, r_reg};
                uop.b_src = BS_MEM;
                uop.b_addr = A_PREV + {4'd0, r_reg};
                uop.neg = 1'b1;
                uop.dst = A_INNOV + {4'd0, r_reg};
            end
            PH_EST:
            begin
                uop.a_src = AS_MEM;
                if (t_reg == 2'd3)
                begin
                    uop.a_addr = A_PREV + {4'd0, r_reg};
                    uop.b_src = BS_ACC;
                    uop.dst = A_PREV + {4'd0, r_reg};
                    uop.out_en = 1'b1;
                    uop.lane = r_reg;
                end
                else
                begin
                    uop.kind = OPK_MUL;
                    uop.b_src = BS_MEM;
                    uop.a_addr = A_K + {2'd0, idx3(r_reg, t_reg)};
                    uop.b_addr = A_INNOV + {4'd0, t_reg};
                    uop.clr = (t_reg == 2'd0);
                end
            end
            PH_IK:
            begin
                uop.a_src = is_diag(idx) ? AS_ONE : AS_ZERO;
                uop.b_src = BS_MEM;
                uop.b_addr = A_K + {2'd0, idx};
                uop.neg = 1'b1;
                uop.dst = A_IK + {2'd0, idx};
            end
            PH_P:
            begin
                uop.kind = OPK_MUL;
                uop.a_src = AS_MEM;
                uop.b_src = BS_MEM;
                uop.a_addr = A_IK + {2'd0, idx3(r_reg, t_reg)};
                uop.b_addr = A_PP + {2'd0, idx3(t_reg, c_reg)};
                uop.clr = (t_reg == 2'd0);
                uop.wr = (t_reg == 2'd2);
                uop.dst = A_P + {2'd0, idx};
            end
            default:
            begin
                uop.kind = OPK_ADD;
            end
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_COF:  end_t = 2'd1;
            PH_DET:  end_t = 2'd2;
            PH_M:    end_t = 2'd3;
            PH_EST:  end_t = 2'd3;
            PH_P:    end_t = 2'd2;
            default: end_t = 2'd0;
        endcase
        case (phase_reg)
            PH_PP:    phase_after = PH_SM;
            PH_SM:    phase_after = PH_COF;
            PH_COF:   phase_after = PH_DET;
            PH_DET:   phase_after = PH_M;
            PH_M:     phase_after = PH_INNOV;
            PH_INNOV: phase_after = PH_EST;
            PH_EST:   phase_after = PH_IK;
            PH_IK:    phase_after = PH_P;
            default:  phase_after = PH_FIRST;
        endcase
        row_only = (phase_reg == PH_FIRST) || (phase_reg == PH_INNOV) || (phase_reg == PH_EST);
    end

    always_comb
    begin
        uop_end = 1'b0;
        case (state_reg)
            ST_EX:   uop_end = (uop.kind == OPK_ADD);
            ST_AC:   uop_end = 1'b1;
            ST_DV:   uop_end = sts.div_done;
            default: uop_end = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        r_next = r_reg;
        c_next = c_reg;
        t_next = t_reg;
        primed_next = primed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd)
                    begin
                        primed_next = 1'b0;
                    end
                    else
                    begin
                        primed_next = 1'b1;
                        phase_next = primed_reg ? PH_PP : PH_FIRST;
                        r_next = 2'd0;
                        c_next = 2'd0;
                        t_next = 2'd0;
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_EX;
            end
            ST_EX:
            begin
                case (uop.kind)
                    OPK_MUL: state_next = ST_AC;
                    OPK_DIV: state_next = ST_DV;
                    default: state_next = ST_EX;
                endcase
            end
            ST_AC, ST_DV, ST_PUSH:
            begin
                if (state_reg == ST_PUSH && sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (uop_end)
        begin
            state_next = ST_RD;
            if (t_reg != end_t)
            begin
                t_next = t_reg + 2'd1;
            end
            else
            begin
                t_next = 2'd0;
                if (row_only || (phase_reg == PH_DET) || (c_reg == 2'd2))
                begin
                    c_next = 2'd0;
                    if ((phase_reg == PH_DET) || (r_reg == 2'd2))
                    begin
                        r_next = 2'd0;
                        if ((phase_reg == PH_FIRST) || (phase_reg == PH_P))
                        begin
                            state_next = ST_PUSH;
                        end
                        phase_next = phase_after;
                    end
                    else
                    begin
                        r_next = r_reg + 2'd1;
                    end
                end
                else
                begin
                    c_next = c_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FIRST;
            r_reg <= 2'd0;
            c_reg <= 2'd0;
            t_reg <= 2'd0;
            primed_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            r_reg <= r_next;
            c_reg <= c_next;
            t_reg <= t_next;
            primed_reg <= primed_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign cmd.load_in = accept;
    assign cmd.restart = accept && in_cmd;
    assign cmd.ex = (state_reg == ST_EX);
    assign cmd.ac = (state_reg == ST_AC);
    assign cmd.dv = (state_reg == ST_DV);
    assign cmd.div_start = (state_reg == ST_EX) && (uop.kind == OPK_DIV);
    assign cmd.push = (state_reg == ST_PUSH) && sts.out_free;
    assign cmd.uop = uop;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the three-axis Kalman filter, driven by directed and random requests.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kf3_pkg::*;

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [30:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;

    kalman_filter_3axis u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    localparam longint ACC_Q [9] = '{11147, 1181, 1171, 1181, 16403, 4594, 1171, 4594, 15432};

    longint    cov [9];
    longint    est_prev [3];
    bit        primed;
    bit        gyro_mode;
    longint    noise_scale;
    out_item_t pending_est [$];
    int        errors;
    int        mismatches;
    bit        calm;
    bit        hold_req;
    stim_row_t rows [$];

    always #5 clk = ~clk;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint mq(longint a, longint b);
        longint p;
        p = a * b + 64'sd8388608;
        return p >>> 24;
    endfunction

    function automatic void filter_restart();
        primed = 0;
        for (int i = 0; i < 3; i++)
        begin
            est_prev[i] = 0;
        end
        for (int i = 0; i < 9; i++)
        begin
            cov[i] = (i % 4 == 0) ? 64'sd16777216 : 64'sd0;
        end
    endfunction

    function automatic bit filter_step(in_item_t it, output out_item_t o);
        longint s [3];
        longint pp [9];
        longint sm [9];
        longint cof [9];
        longint adj [9];
        longint k [9];
        longint ik [9];
        longint innov [3];
        longint est [3];
        longint det;
        longint acc;
        longint m;
        int     r1;
        int     r2;
        int     c1;
        int     c2;
        o = '0;
        if (it.cmd)
        begin
            filter_restart();
            return 0;
        end
        s[0] = longint'(it.sample_x);
        s[1] = longint'(it.sample_y);
        s[2] = longint'(it.sample_z);
        if (!primed)
        begin
            primed = 1;
            for (int r = 0; r < 3; r++)
            begin
                est_prev[r] = s[r];
            end
            o.est_x = it.sample_x;
            o.est_y = it.sample_y;
            o.est_z = it.sample_z;
            return 1;
        end
        for (int r = 0; r < 9; r++)
        begin
            pp[r] = cov[r];
            if (r % 4 == 0)
            begin
                pp[r] = sat(pp[r] + noise_scale);
            end
            sm[r] = sat(pp[r] + (gyro_mode ? ((r % 4 == 0) ? 64'sd16777216 : 64'sd0)
                                           : ACC_Q[r]));
        end
        for (int r = 0; r < 3; r++)
        begin
            r1 = (r + 1) % 3;
            r2 = (r + 2) % 3;
            for (int c = 0; c < 3; c++)
            begin
                c1 = (c + 1) % 3;
                c2 = (c + 2) % 3;
                cof[r * 3 + c] = sat(mq(sm[r1 * 3 + c1], sm[r2 * 3 + c2])
                                     - mq(sm[r1 * 3 + c2], sm[r2 * 3 + c1]));
                adj[c * 3 + r] = cof[r * 3 + c];
            end
        end
        det = 0;
        for (int c = 0; c < 3; c++)
        begin
            det += mq(sm[c], cof[c]);
        end
        det = sat(det);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                begin
                    acc += mq(pp[r * 3 + j], adj[j * 3 + c]);
                end
                m = sat(acc);
                k[r * 3 + c] = (det == 0) ? 64'sd0 : sat((m * 64'sd16777216) / det);
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            innov[r] = sat(s[r] - est_prev[r]);
        end
        for (int r = 0; r < 3; r++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
            begin
                acc += mq(k[r * 3 + j], innov[j]);
            end
            est[r] = sat(est_prev[r] + acc);
        end
        for (int r = 0; r < 3; r++)
        begin
            est_prev[r] = est[r];
        end
        o.est_x = est[0][31:0];
        o.est_y = est[1][31:0];
        o.est_z = est[2][31:0];
        for (int r = 0; r < 9; r++)
        begin
            ik[r] = sat(((r % 4 == 0) ? 64'sd16777216 : 64'sd0) - k[r]);
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                begin
                    acc += mq(ik[r * 3 + j], pp[j * 3 + c]);
                end
                cov[r * 3 + c] = sat(acc);
            end
        end
        return 1;
    endfunction

    task automatic send_request(in_item_t it, bit typed, out_item_t want);
        int        gap;
        out_item_t pred;
        gap = calm ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        if (filter_step(it, pred))
        begin
            pending_est.push_back(typed ? want : pred);
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_est.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SENSOR_MODE)
        begin
            gyro_mode = val[0];
        end
        else
        begin
            noise_scale = longint'(val);
        end
    endtask

    function automatic logic signed [31:0] rand_sample();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7FFFFFFF;
            1:       v = 32'sh80000000;
            2, 3:    v = $urandom();
            default: v = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] rand_noise();
        logic [30:0] v;
        case ($urandom_range(0, 5))
            0:       v = 31'd0;
            1:       v = 31'h7FFFFFFF;
            2:       v = 31'd16777216;
            3:       v = 31'($urandom());
            default: v = 31'($urandom_range(0, 32'd33554432));
        endcase
        return v;
    endfunction

    function automatic in_item_t rand_request();
        in_item_t it;
        it.cmd      = ($urandom_range(0, 19) == 0);
        it.sample_x = rand_sample();
        it.sample_y = rand_sample();
        it.sample_z = rand_sample();
        return it;
    endfunction

    task automatic add_row(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, bit typed);
        stim_row_t row;
        row.req  = '{cmd: cmd, sample_x: x, sample_y: y, sample_z: z};
        row.typed = typed;
        row.want = '{est_x: x, est_y: y, est_z: z};
        rows.push_back(row);
    endtask

    initial
    begin
        int        out_stall;
        out_item_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_stall = calm ? 0 : $urandom_range(0, 18);
            if (out_stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (out_stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            forever
            begin
                @(posedge clk);
                if (out_valid && out_ready)
                begin
                    break;
                end
                if (hold_req)
                begin
                    out_ready <= 1'b0;
                    repeat (6000) @(posedge clk);
                    hold_req = 0;
                    out_ready <= 1'b1;
                end
            end
            if (pending_est.size() == 0)
            begin
                errors++;
                $display("Unexpected result %h with no request outstanding", out_data);
            end
            else
            begin
                want = pending_est.pop_front();
                if (out_data.est_x !== want.est_x || out_data.est_y !== want.est_y
                    || out_data.est_z !== want.est_z)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected %h %h %h, got %h %h %h",
                                 want.est_x, want.est_y, want.est_z,
                                 out_data.est_x, out_data.est_y, out_data.est_z);
                    end
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        out_item_t none;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        none      = '0;
        errors    = 0;
        mismatches = 0;
        calm      = 0;
        hold_req  = 0;
        gyro_mode = 0;
        noise_scale = 64'sd16777216;
        filter_restart();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(1'b0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd0, 1);
        add_row(1'b0, 32'sd0, 32'sd0, 32'sd0, 0);
        add_row(1'b0, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1, 0);
        add_row(1'b0, 32'sh00010000, -32'sh00020000, 32'sh00008000, 0);
        add_row(1'b1, 32'sh12345678, -32'sd5, 32'sh7FFFFFFF, 0);
        add_row(1'b0, -32'sd1, 32'sd1, 32'sh00010000, 1);
        add_row(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        add_row(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        add_row(1'b0, 32'sh00050000, 32'sh00050000, -32'sh00050000, 0);
        add_row(1'b1, 32'sd0, 32'sd0, 32'sd0, 0);
        add_row(1'b1, -32'sd1, -32'sd1, -32'sd1, 0);
        add_row(1'b0, 32'sd0, 32'sd0, 32'sd0, 1);
        add_row(1'b0, 32'sh00100000, -32'sh00100000, 32'sd3, 0);
        add_row(1'b0, 32'sh00100000, -32'sh00100000, 32'sd3, 0);
        foreach (rows[i])
        begin
            send_request(rows[i].req, rows[i].typed, rows[i].want);
        end

        write_reg(REG_SENSOR_MODE, 31'd1);
        write_reg(REG_PROCESS_NOISE, 31'd0);
        for (int i = 0; i < 6; i++)
        begin
            send_request(rand_request(), 0, none);
        end
        write_reg(REG_PROCESS_NOISE, 31'h7FFFFFFF);
        for (int i = 0; i < 6; i++)
        begin
            send_request(rand_request(), 0, none);
        end

        drain_and_settle();
        hold_req = 1;
        calm = 1;
        for (int i = 0; i < 8; i++)
        begin
            send_request(rand_request(), 0, none);
        end
        calm = 0;

        for (int phase = 0; phase < 19; phase++)
        begin
            write_reg(REG_SENSOR_MODE, {30'd0, 1'($urandom_range(0, 1))});
            write_reg(REG_PROCESS_NOISE, rand_noise());
            calm = (phase % 4 == 3);
            for (int i = 0; i < 100; i++)
            begin
                send_request(rand_request(), 0, none);
            end
            calm = 0;
        end

        drain_and_settle();
        repeat (1000) @(posedge clk);
        if (errors == 0 && pending_est.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/kf3_pkg.sv
design/kf3_div.sv
design/kf3_dp.sv
design/kf3_ctrl.sv
design/kalman_filter_3axis.sv
tb/sv/tb.sv
